/* sv/tidm11_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tidm11_pkg
// Shared types, weight tables and mod-11 helper for the tax number validator.
// ----------------------------------------------------------------------------
package tidm11_pkg;

   localparam int DIGIT_W = 4;
   localparam int POS_W   = 4;
   localparam int SUM_W   = 10;
   localparam int KIND_W  = 2;

   localparam logic [POS_W-1:0] POS_MAX       = 4'd15;
   localparam logic [POS_W-1:0] POS_CPF_LAST  = 4'd10;  // eleventh digit
   localparam logic [POS_W-1:0] POS_CNPJ_LAST = 4'd13;  // fourteenth digit

   localparam logic [KIND_W-1:0] KIND_CPF  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CNPJ = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

   // floor(x / 11) = (x * 1490) >> 14 for every 10-bit x
   localparam int          RECIP_SHIFT = 14;
   localparam int          PROD_W      = SUM_W + RECIP_SHIFT;
   localparam int          QUOT_W      = 7;
   localparam logic [10:0] RECIP_11    = 11'd1490;
   localparam logic [3:0]  MOD_BASE    = 4'd11;

   localparam logic [3:0] W_PERSON_FIRST [16] =
      '{4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
        4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] W_PERSON_SECOND [16] =
      '{4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4,
        4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] W_COMPANY_FIRST [16] =
      '{4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6,
        4'd5, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] W_COMPANY_SECOND [16] =
      '{4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7,
        4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0};

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] doc_kind;
      logic              valid_res;
   } rsp_type;

   // Running sums and digit history handed to the check stage
   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [SUM_W-1:0]   person_sum_first;
      logic [SUM_W-1:0]   person_sum_second;
      logic [SUM_W-1:0]   company_sum_first;
      logic [SUM_W-1:0]   company_sum_second;
      logic [DIGIT_W-1:0] previous_digit;
      logic               all_equal;
   } acc_type;

   // Empty number: sums and history cleared, no digit seen to differ
   localparam acc_type ACC_RESET = '{
      position:           '0,
      person_sum_first:   '0,
      person_sum_second:  '0,
      company_sum_first:  '0,
      company_sum_second: '0,
      previous_digit:     '0,
      all_equal:          1'b1
   };

   // Check digit from a weighted sum: 0 when sum mod 11 is below 2
   function automatic logic [3:0] check_digit(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] quot;
      logic [SUM_W-1:0]  rem_w;
      logic [3:0]        rem;
      prod  = PROD_W'(sum) * PROD_W'(RECIP_11);
      quot  = prod[RECIP_SHIFT +: QUOT_W];
      rem_w = sum - SUM_W'(quot) * SUM_W'(MOD_BASE);
      rem   = rem_w[3:0];
      return (rem < 4'd2) ? 4'd0 : MOD_BASE - rem;
   endfunction

endpackage
`default_nettype wire

/* sv/tidm11_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tidm11_check
// Final-digit decision: document kind from length and both mod-11 checks.
// ----------------------------------------------------------------------------
module tidm11_check (
   input  wire tidm11_pkg::acc_type                   acc,
   input  wire logic [tidm11_pkg::DIGIT_W-1:0]        digit,
   input  wire logic                                  digits_differ,
   output tidm11_pkg::rsp_type                        result
);

   logic [3:0] cpf_first;
   logic [3:0] cpf_second;
   logic [3:0] cnpj_first;
   logic [3:0] cnpj_second;

   // The final digit's weight is zero at both legal lengths, so the stored
   // sums already hold the complete totals.
   assign cpf_first   = tidm11_pkg::check_digit(acc.person_sum_first);
   assign cpf_second  = tidm11_pkg::check_digit(acc.person_sum_second);
   assign cnpj_first  = tidm11_pkg::check_digit(acc.company_sum_first);
   assign cnpj_second = tidm11_pkg::check_digit(acc.company_sum_second);

   always_comb begin
      result.doc_kind  = tidm11_pkg::KIND_BAD;
      result.valid_res = 1'b0;
      if (acc.position == tidm11_pkg::POS_CPF_LAST) begin
         result.doc_kind  = tidm11_pkg::KIND_CPF;
         result.valid_res = digits_differ && (cpf_first == acc.previous_digit)
                            && (cpf_second == digit);
      end else if (acc.position == tidm11_pkg::POS_CNPJ_LAST) begin
         result.doc_kind  = tidm11_pkg::KIND_CNPJ;
         result.valid_res = digits_differ && (cnpj_first == acc.previous_digit)
                            && (cnpj_second == digit);
      end
   end

endmodule
`default_nettype wire

/* sv/tax_id_mod11_check_validator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tax_id_mod11_check_validator_unit
// CPF / CNPJ mod-11 check-digit validator, one decimal digit per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one digit per transaction, is_last set on the final digit.
//   rsp_ channel: one transaction per number, carrying doc_kind (CPF, CNPJ
//   or bad length) and valid_res (both check digits match, digits not all
//   equal). Digits that are not final produce no response.
//   Throughput: one digit per cycle while no final digit waits on a stalled
//   response, set by the single accumulate stage between the input register
//   and the result register. An accepted final digit waits in the input
//   register behind any stalled response, then loads rsp_valid and the result.
//   Reset: synchronous; clears both valid flags and restarts the running sums.
//   Stall: while rsp_ready is low a held response blocks only final digits;
//   other digits keep flowing into the accumulator. Once the input register
//   holds a final digit behind a stalled response, req_ready drops.
//   After each final digit the accumulator returns to its reset state.
// ----------------------------------------------------------------------------
module tax_id_mod11_check_validator_unit (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                req_valid,
   output logic                      req_ready,
   input  wire  tidm11_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire  logic                rsp_ready,
   output tidm11_pkg::rsp_type       rsp_data
);

   logic                s1_valid_ff, s1_valid_in;
   tidm11_pkg::req_type s1_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   tidm11_pkg::rsp_type rsp_data_ff;
   tidm11_pkg::acc_type acc_ff, acc_in;
   tidm11_pkg::rsp_type result;

   logic rsp_free;
   logic s1_fire;
   logic digits_differ;
   logic [tidm11_pkg::DIGIT_W-1:0] d;
   logic [tidm11_pkg::POS_W-1:0]   p;

   assign d = s1_data_ff.digit;
   assign p = acc_ff.position;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_data_ff.is_last || rsp_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   // all_equal after this digit, inverted
   assign digits_differ = !acc_ff.all_equal
                          || ((p != '0) && (d != acc_ff.previous_digit));

   tidm11_check u_check (
      .acc           (acc_ff),
      .digit         (d),
      .digits_differ (digits_differ),
      .result        (result)
   );

   always_comb begin
      acc_in = acc_ff;
      if (s1_fire) begin
         if (s1_data_ff.is_last) begin
            acc_in = tidm11_pkg::ACC_RESET;
         end else begin
            acc_in.person_sum_first = acc_ff.person_sum_first
               + tidm11_pkg::SUM_W'(d * tidm11_pkg::W_PERSON_FIRST[p]);
            acc_in.person_sum_second = acc_ff.person_sum_second
               + tidm11_pkg::SUM_W'(d * tidm11_pkg::W_PERSON_SECOND[p]);
            acc_in.company_sum_first = acc_ff.company_sum_first
               + tidm11_pkg::SUM_W'(d * tidm11_pkg::W_COMPANY_FIRST[p]);
            acc_in.company_sum_second = acc_ff.company_sum_second
               + tidm11_pkg::SUM_W'(d * tidm11_pkg::W_COMPANY_SECOND[p]);
            acc_in.previous_digit = d;
            acc_in.all_equal      = !digits_differ;
            acc_in.position       = (p == tidm11_pkg::POS_MAX) ? p : p + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_data_ff.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= tidm11_pkg::ACC_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire && s1_data_ff.is_last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/tidm11_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tidm11_checker
// Port-level checks on the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tidm11_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire tidm11_pkg::req_type req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire tidm11_pkg::rsp_type rsp_data
);

   // Hold a stalled response unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // Come out of reset with no response pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // Never pass a number of bad length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |->
         rsp_data.doc_kind != tidm11_pkg::KIND_BAD)
      else $error("bad length reported as valid");

   // Hold a refused digit unchanged on the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("refused digit changed or withdrawn");

   // Keep accepting digits while no response is pending
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(req_ready) |-> req_ready)
      else $error("input stalled with output idle");

endmodule

bind tax_id_mod11_check_validator_unit tidm11_checker u_tidm11_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* sim/tax_id_mod11_check_validator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tax_id_mod11_check_validator_unit_tb
// Self-checking bench for the CPF / CNPJ check-digit validator. Numbers are
// fed one digit per transaction. A local model of the running sums predicts
// each verdict, and every response is compared with the oldest prediction.
// Traffic is mostly well-formed numbers with correct check digits, plus
// corrupted, all-equal, odd-length and out-of-range-digit numbers, under
// random gaps on both sides and a long response hold-off.
// ----------------------------------------------------------------------------
module tax_id_mod11_check_validator_unit_tb;

   localparam int STALL_LIMIT = 2000;

   typedef enum int {CPF_FIRST, CPF_SECOND, CNPJ_FIRST, CNPJ_SECOND} weight_sel_type;

   localparam logic [3:0] CPF_WEIGHTS_A [16] =
      '{4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
        4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] CPF_WEIGHTS_B [16] =
      '{4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4,
        4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] CNPJ_WEIGHTS_A [16] =
      '{4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6,
        4'd5, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [3:0] CNPJ_WEIGHTS_B [16] =
      '{4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7,
        4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0};

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   tidm11_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   tidm11_pkg::rsp_type rsp_data;

   // model of the number being accumulated
   logic [3:0] digit_count;
   logic [9:0] cpf_sum_a;
   logic [9:0] cpf_sum_b;
   logic [9:0] cnpj_sum_a;
   logic [9:0] cnpj_sum_b;
   logic [3:0] prior_digit;
   logic       digits_same;

   tidm11_pkg::rsp_type verdict_queue [$];
   logic [3:0]          number_digits [24];

   int mismatch_count = 0;
   int send_gap_pct   = 0;
   int rsp_stall_pct  = 0;
   int holdoff_left   = 0;
   int quiet_cycles   = 0;

   tax_id_mod11_check_validator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [3:0] weight_of(input weight_sel_type sel, input logic [3:0] pos);
      case (sel)
         CPF_FIRST:  return CPF_WEIGHTS_A[pos];
         CPF_SECOND: return CPF_WEIGHTS_B[pos];
         CNPJ_FIRST: return CNPJ_WEIGHTS_A[pos];
         default:    return CNPJ_WEIGHTS_B[pos];
      endcase
   endfunction

   function automatic logic [3:0] mod11_digit(input logic [9:0] sum);
      int rem;
      rem = int'(sum) % 11;
      return (rem < 2) ? 4'd0 : 4'(11 - rem);
   endfunction

   // check digit over the first n entries of number_digits
   function automatic logic [3:0] check_over(input weight_sel_type sel, input int n);
      logic [9:0] acc;
      acc = '0;
      for (int i = 0; i < n; i++) begin
         acc = acc + number_digits[i] * weight_of(sel, 4'(i));
      end
      return mod11_digit(acc);
   endfunction

   task automatic clear_number();
      digit_count = '0;
      cpf_sum_a   = '0;
      cpf_sum_b   = '0;
      cnpj_sum_a  = '0;
      cnpj_sum_b  = '0;
      prior_digit = '0;
      digits_same = 1'b1;
   endtask

   task automatic accumulate_digit(input tidm11_pkg::req_type item);
      logic [3:0]          d;
      logic [3:0]          p;
      tidm11_pkg::rsp_type verdict;
      d = item.digit;
      p = digit_count;
      cpf_sum_a  = cpf_sum_a  + d * weight_of(CPF_FIRST, p);
      cpf_sum_b  = cpf_sum_b  + d * weight_of(CPF_SECOND, p);
      cnpj_sum_a = cnpj_sum_a + d * weight_of(CNPJ_FIRST, p);
      cnpj_sum_b = cnpj_sum_b + d * weight_of(CNPJ_SECOND, p);
      if (p != 4'd0 && d != prior_digit) begin
         digits_same = 1'b0;
      end
      if (!item.is_last) begin
         prior_digit = d;
         digit_count = (p < 4'd15) ? p + 4'd1 : 4'd15;
      end else begin
         verdict.doc_kind  = tidm11_pkg::KIND_BAD;
         verdict.valid_res = 1'b0;
         if (p == tidm11_pkg::POS_CPF_LAST) begin
            verdict.doc_kind  = tidm11_pkg::KIND_CPF;
            verdict.valid_res = !digits_same && mod11_digit(cpf_sum_a) == prior_digit &&
                                mod11_digit(cpf_sum_b) == d;
         end else if (p == tidm11_pkg::POS_CNPJ_LAST) begin
            verdict.doc_kind  = tidm11_pkg::KIND_CNPJ;
            verdict.valid_res = !digits_same && mod11_digit(cnpj_sum_a) == prior_digit &&
                                mod11_digit(cnpj_sum_b) == d;
         end
         verdict_queue.push_back(verdict);
         clear_number();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Entered and left at a falling edge; valid stays high on exit so that
   // back-to-back transactions need no second assignment in one step.
   task automatic send_digit(input tidm11_pkg::req_type item);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      accumulate_digit(item);
      @(negedge clock);
   endtask

   task automatic send_number(input int len);
      tidm11_pkg::req_type item;
      for (int i = 0; i < len; i++) begin
         item.digit   = number_digits[i];
         item.is_last = (i == len - 1);
         send_digit(item);
      end
   endtask

   // Fill number_digits with one number and return its length
   task automatic build_number(output int len);
      int pick;
      int body;
      bit company;
      pick = $urandom_range(99);
      if (pick < 65) begin
         // well-formed, check digits computed, sometimes corrupted
         company = (pick >= 35);
         body    = company ? 12 : 9;
         for (int i = 0; i < body; i++) begin
            number_digits[i] = 4'($urandom_range(9));
         end
         number_digits[body]     = check_over(company ? CNPJ_FIRST : CPF_FIRST, body);
         number_digits[body + 1] = check_over(company ? CNPJ_SECOND : CPF_SECOND, body + 1);
         len = body + 2;
         if ($urandom_range(99) < 20) begin
            // hit the final digit half the time so the first check still passes
            if ($urandom_range(1) == 0) begin
               number_digits[len - 1] = 4'($urandom_range(15));
            end else begin
               number_digits[$urandom_range(len - 1)] = 4'($urandom_range(15));
            end
         end
      end else if (pick < 75) begin
         len = ($urandom_range(1) == 0) ? 11 : 14;
         body = $urandom_range(15);
         for (int i = 0; i < len; i++) begin
            number_digits[i] = 4'(body);
         end
      end else if (pick < 90) begin
         len = $urandom_range(20, 1);
         for (int i = 0; i < len; i++) begin
            number_digits[i] = 4'($urandom_range(15));
         end
      end else begin
         len = ($urandom_range(1) == 0) ? 11 : 14;
         for (int i = 0; i < len; i++) begin
            number_digits[i] = 4'($urandom_range(15));
         end
      end
   endtask

   task automatic run_numbers(input int item_goal);
      int sent;
      int len;
      sent = 0;
      while (sent < item_goal) begin
         build_number(len);
         send_number(len);
         sent += len;
      end
   endtask

   task automatic wait_drained();
      while (verdict_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic load_digits(input string text);
      for (int i = 0; i < text.len(); i++) begin
         number_digits[i] = 4'(text[i] - "0");
      end
   endtask

   task automatic test_directed();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      load_digits("52998224725");
      send_number(11);
      load_digits("11222333000181");
      send_number(14);
      // lone digit above nine: bad length
      number_digits[0] = 4'd15;
      send_number(1);
   endtask

   task automatic test_sender_gaps();
      send_gap_pct  = 21;
      rsp_stall_pct = 54;
      run_numbers(650);
   endtask

   task automatic test_receiver_gaps();
      send_gap_pct  = 54;
      rsp_stall_pct = 21;
      run_numbers(650);
   endtask

   task automatic test_full_rate();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      run_numbers(500);
   endtask

   task automatic test_response_holdoff();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      holdoff_left  = 80;
      run_numbers(100);
   endtask

   task automatic test_drain_pause();
      int len;
      send_gap_pct  = 21;
      rsp_stall_pct = 21;
      repeat (6) begin
         build_number(len);
         send_number(len);
         req_valid <= 1'b0;
         @(negedge clock);
         wait_drained();
      end
   endtask

   // response side: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready <= 1'b0;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      tidm11_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind %0d valid %0b",
                                      rsp_data.doc_kind, rsp_data.valid_res));
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_data.doc_kind !== want.doc_kind) begin
               report_mismatch($sformatf("doc_kind %0d, expected %0d",
                                         rsp_data.doc_kind, want.doc_kind));
            end
            if (rsp_data.valid_res !== want.valid_res) begin
               report_mismatch($sformatf("valid_res %0b, expected %0b",
                                         rsp_data.valid_res, want.valid_res));
            end
         end
      end
   end

   // watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      clear_number();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_sender_gaps();
      test_receiver_gaps();
      test_full_rate();
      test_response_holdoff();
      test_drain_pause();

      req_valid <= 1'b0;
      @(negedge clock);
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
